[rtl/command_retry_ack_tracker_macros.svh]
// Assertion helpers shared by the tracker RTL.
// Both expect clk_i and rst_ni in scope.
`ifndef COMMAND_RETRY_ACK_TRACKER_MACROS_SVH
`define COMMAND_RETRY_ACK_TRACKER_MACROS_SVH

// same-cycle implication
`define CRAT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crat: same-cycle check failed");

// next-cycle implication
`define CRAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crat: next-cycle check failed");

`endif

[rtl/crat_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package crat_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned SeqW   = 8;
  localparam int unsigned RetryW = 4;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned CntW   = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [MsW-1:0]    CommandPeriodRst = 16'd2000;
  localparam logic [MsW-1:0]    RetryIntervalRst = 16'd100;
  localparam logic [RetryW-1:0] MaxRetriesRst    = 4'd2;
  localparam logic [MsW-1:0]    PulseLengthRst   = 16'd150;
  localparam logic [CodeW-1:0]  CommandCodeRst   = 8'h01;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COMMAND_PERIOD = 3'd0,
    REG_RETRY_INTERVAL = 3'd1,
    REG_MAX_RETRIES    = 3'd2,
    REG_PULSE_LENGTH   = 3'd3,
    REG_COMMAND_CODE   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             ack_valid;
    logic             ack_for_command;
    logic [SeqW-1:0]  ack_seq;
    logic [7:0]       ack_status;
    logic             tx_ready;
  } in_t;

  typedef struct packed {
    logic             send_valid;
    logic             send_is_retry;
    logic [SeqW-1:0]  send_seq;
    logic             send_mode;
    logic [CodeW-1:0] send_code;
    logic             pending_out;
    logic             activity_on;
    logic [CntW-1:0]  successes;
    logic [CntW-1:0]  timeouts;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [MsW-1:0]    command_period_ms;
    logic [MsW-1:0]    retry_interval_ms;
    logic [RetryW-1:0] max_retries;
    logic [MsW-1:0]    pulse_length_ms;
    logic [CodeW-1:0]  command_code;
  } cfg_regs_t;

endpackage

`default_nettype wire

[rtl/crat_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface crat_poll_if;
  logic           valid;
  logic           ready;
  crat_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crat_res_if;
  logic           valid;
  logic           ready;
  crat_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crat_cfg_if;
  logic              valid;
  logic              ready;
  crat_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/crat_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module crat_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  crat_cfg_if.sink            cfg_i,
  output crat_pkg::cfg_regs_t regs_o
);
  import crat_pkg::*;

  cfg_regs_t regs_q, regs_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.data.index))
        REG_COMMAND_PERIOD: regs_d.command_period_ms = cfg_i.data.wdata;
        REG_RETRY_INTERVAL: regs_d.retry_interval_ms = cfg_i.data.wdata;
        REG_MAX_RETRIES:    regs_d.max_retries = cfg_i.data.wdata[RetryW-1:0];
        REG_PULSE_LENGTH:   regs_d.pulse_length_ms = cfg_i.data.wdata;
        REG_COMMAND_CODE:   regs_d.command_code = cfg_i.data.wdata[CodeW-1:0];
        default: ; // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.command_period_ms <= CommandPeriodRst;
      regs_q.retry_interval_ms <= RetryIntervalRst;
      regs_q.max_retries       <= MaxRetriesRst;
      regs_q.pulse_length_ms   <= PulseLengthRst;
      regs_q.command_code      <= CommandCodeRst;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

`default_nettype wire

[rtl/crat_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module crat_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  crat_poll_if.sink     poll_i,
  output logic          item_valid_o,
  output crat_pkg::in_t item_o,
  input  logic          item_ready_i
);
  import crat_pkg::*;

  logic valid_q, valid_d;
  in_t  data_q;
  logic take;

  // accept when empty or when the held transaction moves on this cycle
  assign poll_i.ready = !valid_q || item_ready_i;
  assign take = poll_i.valid && poll_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= poll_i.data;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

`default_nettype wire

[rtl/crat_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "command_retry_ack_tracker_macros.svh"

module crat_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crat_pkg::cfg_regs_t cfg_i,
  input  logic                item_valid_i,
  input  crat_pkg::in_t       item_i,
  output logic                item_ready_o,
  crat_res_if.source          result_o
);
  import crat_pkg::*;

  logic              pending_q, pending_d;
  logic [RetryW-1:0] retry_count_q, retry_count_d;
  logic [SeqW-1:0]   next_seq_q, next_seq_d;
  logic [SeqW-1:0]   pending_seq_q, pending_seq_d;
  logic              mode_q, mode_d;
  logic [TimeW-1:0]  last_send_q, last_send_d;
  logic [TimeW-1:0]  pulse_until_q, pulse_until_d;
  logic [CntW-1:0]   success_total_q, success_total_d;
  logic [CntW-1:0]   timeout_total_q, timeout_total_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, res_d;

  logic             fire;
  logic             ack_match;
  logic             pend_after_ack;
  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] pulse_left;
  logic             send_new;
  logic             retry_due;
  logic             give_up;

  assign item_ready_o = !out_valid_q || result_o.ready;
  assign fire = item_valid_i && item_ready_o;

  assign ack_match = item_i.ack_valid && pending_q && item_i.ack_for_command &&
                     (item_i.ack_seq == pending_seq_q) && (item_i.ack_status == 8'd0);
  assign pend_after_ack = pending_q && !ack_match;
  assign elapsed   = item_i.now_ms - last_send_q;
  assign send_new  = !pend_after_ack && (elapsed >= {16'd0, cfg_i.command_period_ms});
  assign retry_due = pend_after_ack && (elapsed >= {16'd0, cfg_i.retry_interval_ms});
  assign give_up   = retry_due && !(retry_count_q < cfg_i.max_retries);

  always_comb begin
    pending_d       = pend_after_ack;
    retry_count_d   = retry_count_q;
    next_seq_d      = next_seq_q;
    pending_seq_d   = pending_seq_q;
    mode_d          = mode_q ^ ack_match;
    last_send_d     = last_send_q;
    pulse_until_d   = pulse_until_q;
    success_total_d = success_total_q;
    timeout_total_d = timeout_total_q;
    res_d           = '0;

    if (ack_match) begin
      success_total_d = success_total_q + 32'd1;
      pulse_until_d   = item_i.now_ms + {16'd0, cfg_i.pulse_length_ms};
    end

    if (send_new) begin
      // the sequence number is consumed even when the transmitter refuses
      pending_seq_d = next_seq_q;
      next_seq_d    = next_seq_q + 8'd1;
      if (item_i.tx_ready) begin
        res_d.send_valid = 1'b1;
        res_d.send_seq   = next_seq_q;
        res_d.send_mode  = mode_d;
        res_d.send_code  = cfg_i.command_code;
        pending_d        = 1'b1;
        retry_count_d    = '0;
        last_send_d      = item_i.now_ms;
      end
    end else if (retry_due) begin
      last_send_d = item_i.now_ms;
      if (give_up) begin
        pending_d       = 1'b0;
        timeout_total_d = timeout_total_q + 32'd1;
      end else begin
        retry_count_d = retry_count_q + 4'd1;
        if (item_i.tx_ready) begin
          res_d.send_valid    = 1'b1;
          res_d.send_is_retry = 1'b1;
          res_d.send_seq      = pending_seq_q;
          res_d.send_mode     = mode_d;
          res_d.send_code     = cfg_i.command_code;
        end
      end
    end

    pulse_left        = pulse_until_d - item_i.now_ms;
    res_d.pending_out = pending_d;
    res_d.activity_on = (pulse_left != '0) && !pulse_left[TimeW-1];
    res_d.successes   = success_total_d;
    res_d.timeouts    = timeout_total_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q       <= 1'b0;
      retry_count_q   <= '0;
      next_seq_q      <= '0;
      pending_seq_q   <= '0;
      mode_q          <= 1'b0;
      last_send_q     <= '0;
      pulse_until_q   <= '0;
      success_total_q <= '0;
      timeout_total_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      // advance state only with an accepted transaction
      if (fire) begin
        pending_q       <= pending_d;
        retry_count_q   <= retry_count_d;
        next_seq_q      <= next_seq_d;
        pending_seq_q   <= pending_seq_d;
        mode_q          <= mode_d;
        last_send_q     <= last_send_d;
        pulse_until_q   <= pulse_until_d;
        success_total_q <= success_total_d;
        timeout_total_q <= timeout_total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  `CRAT_ASSERT_NEXT(a_new_send_sets_pending, fire && send_new && item_i.tx_ready, pending_q)
  `CRAT_ASSERT_NEXT(a_success_only_on_match, !(fire && ack_match), $stable(success_total_q))
  `CRAT_ASSERT_NEXT(a_seq_only_on_new, !(fire && send_new), $stable(next_seq_q))
  `CRAT_ASSERT_NEXT(a_give_up_clears, fire && give_up,
                    !pending_q && out_valid_q && !out_q.pending_out)
  `CRAT_ASSERT_NOW(a_give_up_needs_pending, give_up, pending_q && !send_new)

endmodule

`default_nettype wire

[rtl/command_retry_ack_tracker.sv]
// Stop-and-wait command sender with retry and acknowledge tracking.
// poll_i carries one poll per transaction: the millisecond time, an optional
// acknowledge and the transmitter's readiness. result_o returns exactly one
// result per poll: the command frame to send (if any), the pending flag, the
// activity pulse and the success and timeout counters.
// cfg_i writes the five setup registers by index; it is always ready and is
// meant to be written while no poll is in flight. Writes past index 4 drop.
// A poll is registered in the input stage on accept; the engine computes its
// result from that register and registers it in the result register, which
// drives result_o.
// Throughput: one poll per cycle while result_o is ready; the whole state
// update is one short compare/add path from input to result register.
// A stalled result_o holds its result; the input register keeps accepting
// until both stages are full, then poll_i.ready drops.
// Reset (rst_ni low, asynchronous) clears all state and counters, restores
// the register defaults (2000, 100, 2, 150, 0x01) and empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module command_retry_ack_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  crat_poll_if.sink  poll_i,
  crat_res_if.source result_o,
  crat_cfg_if.sink   cfg_i
);
  import crat_pkg::*;

  cfg_regs_t regs;
  logic      item_valid;
  logic      item_ready;
  in_t       item;

  crat_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  crat_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .poll_i       (poll_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  crat_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (regs),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire
